>>> sv/ssdv32_pkg.sv
`timescale 1ns / 1ps
package ssdv32_pkg;

    localparam int WORD_W   = 16;
    localparam int FB_W     = 32;
    localparam int SHIFT_W  = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // split mode: a group of six bits handled as two halves of three
    localparam logic [SHIFT_W-1:0] SPLIT_GROUP = 5'd6;
    localparam logic [SHIFT_W-1:0] SPLIT_SHIFT = 5'd3;
    localparam int HALF_W = 3;

    localparam logic [SHIFT_W-1:0] GROUP_BITS_RST = 5'd4;
    localparam logic [SHIFT_W-1:0] TAP_FIRST_RST  = 5'd5;
    localparam logic [SHIFT_W-1:0] TAP_SECOND_RST = 5'd18;
    localparam logic [WORD_W-1:0]  OUT_MASK_RST   = 16'hFFFF;
    localparam logic [FB_W-1:0]    REG_MASK_RST   = 32'h007F_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GROUP_BITS = 3'd0,
        CFG_TAP_FIRST  = 3'd1,
        CFG_TAP_SECOND = 3'd2,
        CFG_OUT_MASK   = 3'd3,
        CFG_REG_MASK   = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [WORD_W-1:0] rx_word;
        logic              last_in_buffer;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] plain_word;
        logic              last_out;
    } out_item_t;

    typedef struct packed {
        logic [SHIFT_W-1:0] group_bits;
        logic [SHIFT_W-1:0] tap_first;
        logic [SHIFT_W-1:0] tap_second;
        logic [WORD_W-1:0]  out_mask;
        logic [FB_W-1:0]    reg_mask;
    } cfg_t;

endpackage

>>> sv/self_sync_descrambler_v32_top.sv
`timescale 1ns / 1ps
// a word passes the input register, then the result register; m_valid rises when it
// moves on, which waits while the result register is full and m_ready is low
// throughput: one word per cycle while m_ready stays high; the feedback register is
// updated in the cycle a word moves from the input register to the result register
// reset: synchronous, active low; clears both valid flags and the feedback register
// and returns the configuration registers to their defaults
module self_sync_descrambler_v32_top
    import ssdv32_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t              cfg_reg;
    cfg_t              cfg_next;
    logic [FB_W-1:0]   fb_reg;
    logic [FB_W-1:0]   fb_next;
    logic              in_valid_reg;
    in_item_t          in_data_reg;
    logic              out_valid_reg;
    out_item_t         out_data_reg;
    logic              move;
    logic [WORD_W-1:0] plain_word;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_GROUP_BITS: cfg_next.group_bits = cfg_data[SHIFT_W-1:0];
                CFG_TAP_FIRST:  cfg_next.tap_first  = cfg_data[SHIFT_W-1:0];
                CFG_TAP_SECOND: cfg_next.tap_second = cfg_data[SHIFT_W-1:0];
                CFG_OUT_MASK:   cfg_next.out_mask   = cfg_data[WORD_W-1:0];
                CFG_REG_MASK:   cfg_next.reg_mask   = cfg_data[FB_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.group_bits <= GROUP_BITS_RST;
            cfg_reg.tap_first  <= TAP_FIRST_RST;
            cfg_reg.tap_second <= TAP_SECOND_RST;
            cfg_reg.out_mask   <= OUT_MASK_RST;
            cfg_reg.reg_mask   <= REG_MASK_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ssdv32_core u_core (
        .cfg        (cfg_reg),
        .fb         (fb_reg),
        .rx_word    (in_data_reg.rx_word),
        .plain_word (plain_word),
        .fb_next    (fb_next)
    );

    // word leaves the input register when the result register is free or draining
    assign move    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || move;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fb_reg        <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (move) begin
                in_valid_reg <= 1'b0;
            end
            if (move) begin
                out_valid_reg <= 1'b1;
                fb_reg        <= fb_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (move) begin
            out_data_reg.plain_word <= plain_word;
            out_data_reg.last_out   <= in_data_reg.last_in_buffer;
        end
    end

endmodule

>>> sv/ssdv32_core.sv
`timescale 1ns / 1ps
module ssdv32_core
    import ssdv32_pkg::*;
(
    input  cfg_t              cfg,
    input  logic [FB_W-1:0]   fb,
    input  logic [WORD_W-1:0] rx_word,
    output logic [WORD_W-1:0] plain_word,
    output logic [FB_W-1:0]   fb_next
);

    logic [FB_W-1:0]   tap_a_first;
    logic [FB_W-1:0]   tap_a_second;
    logic [FB_W-1:0]   tap_b_first;
    logic [FB_W-1:0]   tap_b_second;
    logic [FB_W-1:0]   fb_mid;
    logic [FB_W-1:0]   hi_in;
    logic [FB_W-1:0]   lo_in;
    logic [FB_W-1:0]   word_in;
    logic [WORD_W-1:0] y_hi;
    logic [WORD_W-1:0] y_lo;
    logic [WORD_W-1:0] y_whole;
    logic [FB_W-1:0]   fb_whole;
    logic [FB_W-1:0]   fb_split;
    logic [WORD_W-1:0] y_split;

    assign hi_in   = {{(FB_W-HALF_W){1'b0}}, rx_word[2*HALF_W-1:HALF_W]};
    assign lo_in   = {{(FB_W-HALF_W){1'b0}}, rx_word[HALF_W-1:0]};
    assign word_in = {{(FB_W-WORD_W){1'b0}}, rx_word};

    // first pass: whole word, or the upper half in split mode
    assign tap_a_first  = fb >> cfg.tap_first;
    assign tap_a_second = fb >> cfg.tap_second;

    assign y_whole  = (rx_word ^ tap_a_first[WORD_W-1:0] ^ tap_a_second[WORD_W-1:0])
                      & cfg.out_mask;
    assign fb_whole = ((fb << cfg.group_bits) & cfg.reg_mask) | word_in;

    assign y_hi   = (hi_in[WORD_W-1:0] ^ tap_a_first[WORD_W-1:0] ^ tap_a_second[WORD_W-1:0])
                    & cfg.out_mask;
    assign fb_mid = ((fb << SPLIT_SHIFT) & cfg.reg_mask) | hi_in;

    // second half sees the register after the first half
    assign tap_b_first  = fb_mid >> cfg.tap_first;
    assign tap_b_second = fb_mid >> cfg.tap_second;

    assign y_lo     = (lo_in[WORD_W-1:0] ^ tap_b_first[WORD_W-1:0] ^ tap_b_second[WORD_W-1:0])
                      & cfg.out_mask;
    assign fb_split = ((fb_mid << SPLIT_SHIFT) & cfg.reg_mask) | lo_in;
    assign y_split  = (y_hi << SPLIT_SHIFT) | y_lo;

    always_comb begin
        if (cfg.group_bits == SPLIT_GROUP) begin
            plain_word = y_split;
            fb_next    = fb_split;
        end else begin
            plain_word = y_whole;
            fb_next    = fb_whole;
        end
    end

endmodule

>>> sv/ssdv32_checker.sv
`timescale 1ns / 1ps
module ssdv32_checker
    import ssdv32_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input in_item_t              s_data,
    input logic                  m_valid,
    input logic                  m_ready,
    input out_item_t             m_data,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_addr,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // reset empties the result side
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // input stalls only when both stages are full and the sink is stalling
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output backpressure");

    // a fresh result follows a word accepted earlier through the input register
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result appeared without a matching input word");

endmodule

bind self_sync_descrambler_v32_top ssdv32_checker u_ssdv32_checker (.*);

>>> test/tb.sv
`timescale 1ns / 1ps
module tb;
    import ssdv32_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned RANDOM_WORDS = 1100;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned REPORT_CAP   = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(CFG_REG_MASK) + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = {CFG_IDX_W{1'b1}};

    // keeps its own copy of the feedback register and settings and queues the
    // plain words the block must return
    class descrambler_scoreboard;
        logic [SHIFT_W-1:0] group_bits;
        logic [SHIFT_W-1:0] tap_a;
        logic [SHIFT_W-1:0] tap_b;
        logic [WORD_W-1:0]  out_mask;
        logic [FB_W-1:0]    reg_mask;
        logic [FB_W-1:0]    feedback;
        out_item_t          plain_q[$];
        int unsigned        errors;

        function new();
            group_bits = GROUP_BITS_RST;
            tap_a      = TAP_FIRST_RST;
            tap_b      = TAP_SECOND_RST;
            out_mask   = OUT_MASK_RST;
            reg_mask   = REG_MASK_RST;
            feedback   = '0;
            errors     = 0;
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            case (addr)
                CFG_GROUP_BITS: group_bits = data[SHIFT_W-1:0];
                CFG_TAP_FIRST:  tap_a = data[SHIFT_W-1:0];
                CFG_TAP_SECOND: tap_b = data[SHIFT_W-1:0];
                CFG_OUT_MASK:   out_mask = data[WORD_W-1:0];
                CFG_REG_MASK:   reg_mask = data[FB_W-1:0];
                default: ;
            endcase
        endfunction

        // one pass: xor with both taps, then shift the received value in
        function logic [WORD_W-1:0] unscramble(logic [WORD_W-1:0] v, logic [SHIFT_W-1:0] sh);
            logic [FB_W-1:0] r;
            logic [FB_W-1:0] mix;
            r = feedback;
            mix = FB_W'(v) ^ (r >> tap_a) ^ (r >> tap_b);
            feedback = ((r << sh) & reg_mask) | FB_W'(v);
            return mix[WORD_W-1:0] & out_mask;
        endfunction

        function void note_word(in_item_t w);
            out_item_t e;
            logic [WORD_W-1:0] hi;
            logic [WORD_W-1:0] lo;
            if (group_bits == SPLIT_GROUP) begin
                // upper half first, the lower half sees the updated register
                hi = unscramble(WORD_W'(w.rx_word[2*HALF_W-1:HALF_W]), SPLIT_SHIFT);
                lo = unscramble(WORD_W'(w.rx_word[HALF_W-1:0]), SPLIT_SHIFT);
                e.plain_word = (hi << HALF_W) | lo;
            end else begin
                e.plain_word = unscramble(w.rx_word, group_bits);
            end
            e.last_out = w.last_in_buffer;
            plain_q.push_back(e);
        endfunction

        task report(string msg);
            if (errors < REPORT_CAP)
                $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check(out_item_t got);
            out_item_t e;
            if (plain_q.size() == 0) begin
                report($sformatf("word %h with none outstanding", got.plain_word));
                return;
            end
            e = plain_q.pop_front();
            if (got.plain_word !== e.plain_word)
                report($sformatf("plain_word %h, wanted %h", got.plain_word, e.plain_word));
            if (got.last_out !== e.last_out)
                report($sformatf("last_out %b, wanted %b", got.last_out, e.last_out));
        endtask

        function int unsigned pending();
            return plain_q.size();
        endfunction

        task close_out();
            if (plain_q.size() != 0)
                report($sformatf("%0d words never returned", plain_q.size()));
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    descrambler_scoreboard sb;
    logic                  calm = 1'b0;
    int unsigned           cycles = 0;

    self_sync_descrambler_v32_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check(m_data);
            if (s_valid && s_ready)
                sb.note_word(s_data);
            if (cfg_valid && cfg_ready)
                sb.note_config(cfg_addr, cfg_data);
        end
    end

    // mostly short gaps, now and then a long one, none in calm phases
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial begin
        int unsigned stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            stall = pick_gap();
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    task automatic send_word(input logic [WORD_W-1:0] w, input logic last);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{rx_word: w, last_in_buffer: last};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // narrow registers get random upper bits, which must be dropped
    task automatic load_settings(input logic [SHIFT_W-1:0] g, input logic [SHIFT_W-1:0] ta,
                                 input logic [SHIFT_W-1:0] tb_, input logic [WORD_W-1:0] om,
                                 input logic [FB_W-1:0] rm, input logic spare);
        logic [CFG_DATA_W-1:0] junk;
        if (spare)
            write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), $urandom());
        junk = $urandom();
        write_reg(CFG_GROUP_BITS, {junk[CFG_DATA_W-1:SHIFT_W], g});
        junk = $urandom();
        write_reg(CFG_TAP_FIRST, {junk[CFG_DATA_W-1:SHIFT_W], ta});
        junk = $urandom();
        write_reg(CFG_TAP_SECOND, {junk[CFG_DATA_W-1:SHIFT_W], tb_});
        junk = $urandom();
        write_reg(CFG_OUT_MASK, {junk[CFG_DATA_W-1:WORD_W], om});
        write_reg(CFG_REG_MASK, rm);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_random_settings();
        logic [SHIFT_W-1:0] g;
        logic [SHIFT_W-1:0] ta;
        logic [SHIFT_W-1:0] tb_;
        logic [WORD_W-1:0]  om;
        logic [FB_W-1:0]    rm;
        int unsigned        roll;
        roll = $urandom_range(0, 9);
        if (roll < 4)
            g = SPLIT_GROUP;
        else if (roll < 6)
            g = GROUP_BITS_RST;
        else if (roll < 9)
            g = SHIFT_W'($urandom_range(0, 16));
        else
            g = SHIFT_W'($urandom_range(17, 31));
        ta = SHIFT_W'($urandom_range(0, 31));
        tb_ = SHIFT_W'($urandom_range(0, 31));
        om = ($urandom_range(0, 9) < 6) ? 16'hFFFF : 16'($urandom());
        case ($urandom_range(0, 3))
            0: rm = REG_MASK_RST;
            1: rm = $urandom();
            2: rm = (32'h1 << $urandom_range(1, 31)) - 1;
            default: rm = 32'hFFFF_FFFF;
        endcase
        load_settings(g, ta, tb_, om, rm, $urandom_range(0, 3) == 0);
    endtask

    initial begin
        logic [WORD_W-1:0] dir_plain [8] = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555,
                                             16'h0038, 16'h0007, 16'h8001, 16'hFFFF};
        logic [WORD_W-1:0] dir_split [6] = '{16'hFFFF, 16'h0038, 16'h0007, 16'hFFC0,
                                             16'h002A, 16'h0015};
        logic [WORD_W-1:0] dir_wide [5]  = '{16'h0001, 16'h8000, 16'hFFFF, 16'h1234,
                                             16'hFFFF};
        logic [WORD_W-1:0] dir_narrow [5] = '{16'hFFFF, 16'h0000, 16'h5A5A, 16'hFFFF,
                                              16'h0001};
        int unsigned total;
        int unsigned n;

        sb = new();
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        cfg_valid <= 1'b0;
        cfg_addr <= '0;
        cfg_data <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // settings out of reset
        foreach (dir_plain[i]) send_word(dir_plain[i], (i % 3) == 1);
        drain();

        // split mode, bits above the six-bit group are ignored
        load_settings(SPLIT_GROUP, TAP_FIRST_RST, TAP_SECOND_RST, OUT_MASK_RST,
                      REG_MASK_RST, 1'b1);
        foreach (dir_split[i]) send_word(dir_split[i], (i % 2) == 1);
        drain();

        // widest shift, tap extremes, full register
        load_settings(5'd31, 5'd0, 5'd31, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        foreach (dir_wide[i]) send_word(dir_wide[i], i == 4);
        drain();

        // no shift, everything masked away
        load_settings(5'd0, 5'd31, 5'd0, 16'h0000, 32'h0000_0000, 1'b1);
        foreach (dir_narrow[i]) send_word(dir_narrow[i], i == 0);
        drain();

        total = 0;
        while (total < RANDOM_WORDS) begin
            write_random_settings();
            calm = ($urandom_range(0, 4) == 0);
            n = $urandom_range(30, 130);
            repeat (n) send_word(WORD_W'($urandom_range(0, 16'hFFFF)),
                                 $urandom_range(0, 7) == 0);
            total += n;
            drain();
        end

        sb.close_out();
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
sv/ssdv32_pkg.sv
sv/ssdv32_core.sv
sv/self_sync_descrambler_v32_top.sv
sv/ssdv32_checker.sv
test/tb.sv
